// File: rtl/mrc_pkg.sv
// Package for the Modbus RTU response checker: transaction structs, codes,
// the CRC-16 byte update and the command queue default depth.
// No dependencies.
`default_nettype none

package mrc_pkg;

    // Input selector codes
    localparam logic [1:0] FUNC_ARM     = 2'd0;
    localparam logic [1:0] FUNC_BYTE    = 2'd1;
    localparam logic [1:0] FUNC_TIMEOUT = 2'd2;

    // Result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Status codes
    localparam logic [2:0] ERR_OK       = 3'd0;
    localparam logic [2:0] ERR_SHORT    = 3'd1;
    localparam logic [2:0] ERR_CRC      = 3'd2;
    localparam logic [2:0] ERR_ADDR     = 3'd3;
    localparam logic [2:0] ERR_FUNCTION = 3'd4;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [9:0] LEN_MAX   = 10'd1023;
    localparam logic [9:0] LEN_WRITE = 10'd8;
    localparam logic [9:0] DATA_START = 10'd3;

    localparam int QDEPTH_DEFAULT = 4;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] rx_byte;
        logic [7:0] slave_addr;
        logic [7:0] function_code;
        logic [8:0] quantity;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [15:0] data_value;
        logic [7:0]  data_index;
        logic [2:0]  error_code;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_ARM     = 2'd0,
        OP_BYTE    = 2'd1,
        OP_TIMEOUT = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_BITS  = 2'd1,
        MODE_REGS  = 2'd2
    } t_read_mode;

    // Classified command handed from front to back
    typedef struct packed {
        t_op        op;
        logic [7:0] rx_byte;
        logic [7:0] slave_addr;
        logic [7:0] function_code;
        t_read_mode mode;
        logic [9:0] length;
    } t_cmd;

    // Modbus CRC-16, one byte, LSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/mrc_front.sv
// Front end: takes input transactions, flags unused selectors to be dropped,
// works out the expected frame length for arm requests. Depends on mrc_pkg.
`default_nettype none

module mrc_front (
    input  wire mrc_pkg::t_in_item i_item,
    output mrc_pkg::t_cmd          o_cmd,
    output logic                   o_keep
);
    import mrc_pkg::*;

    logic [9:0]  w_qty_rnd;
    logic [10:0] w_len_bits;
    logic [10:0] w_len_regs;
    logic [10:0] w_len_wide;
    t_read_mode  w_mode;

    assign w_qty_rnd  = {1'b0, i_item.quantity} + 10'd7;
    assign w_len_bits = 11'd5 + {4'd0, w_qty_rnd[9:3]};
    assign w_len_regs = 11'd5 + {1'b0, i_item.quantity, 1'b0};

    always_comb begin
        case (i_item.function_code) inside
            8'd1, 8'd2: begin
                w_mode     = MODE_BITS;
                w_len_wide = w_len_bits;
            end
            8'd3, 8'd4: begin
                w_mode     = MODE_REGS;
                w_len_wide = w_len_regs;
            end
            default: begin
                w_mode     = MODE_WRITE;
                w_len_wide = {1'b0, LEN_WRITE};
            end
        endcase
    end

    always_comb begin
        o_cmd.rx_byte       = i_item.rx_byte;
        o_cmd.slave_addr    = i_item.slave_addr;
        o_cmd.function_code = i_item.function_code;
        o_cmd.mode          = w_mode;
        o_cmd.length        = w_len_wide[10] ? LEN_MAX : w_len_wide[9:0];
        case (i_item.func)
            FUNC_ARM: begin
                o_cmd.op = OP_ARM;
                o_keep   = 1'b1;
            end
            FUNC_BYTE: begin
                o_cmd.op = OP_BYTE;
                o_keep   = 1'b1;
            end
            FUNC_TIMEOUT: begin
                o_cmd.op = OP_TIMEOUT;
                o_keep   = 1'b1;
            end
            default: begin
                o_cmd.op = OP_BYTE;
                o_keep   = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/mrc_queue.sv
// Small command FIFO between front and back ends.
// Depends on mrc_pkg for the command type.
`default_nettype none

module mrc_queue #(
    parameter int QUEUE_DEPTH = mrc_pkg::QDEPTH_DEFAULT
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  wire mrc_pkg::t_cmd  i_cmd,
    output logic                o_full,
    input  wire                 i_pop,
    output logic                o_valid,
    output mrc_pkg::t_cmd       o_cmd
);
    import mrc_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST  = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL  = CW'(QUEUE_DEPTH);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

// File: rtl/mrc_back.sv
// Back end: frame state, running CRC, data extraction and status, with the
// output register. Depends on mrc_pkg.
`default_nettype none

module mrc_back (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cmd_valid,
    input  wire mrc_pkg::t_cmd      i_cmd,
    output logic                    o_cmd_pop,
    output logic                    o_out_valid,
    input  wire                     i_out_ready,
    output mrc_pkg::t_out_item      o_out_item
);
    import mrc_pkg::*;

    logic        r_armed,      n_armed;
    logic [15:0] r_crc,        n_crc;
    logic [9:0]  r_byte_count, n_byte_count;
    logic [9:0]  r_length,     n_length;
    logic [7:0]  r_exp_addr,   n_exp_addr;
    logic [7:0]  r_exp_code,   n_exp_code;
    t_read_mode  r_mode,       n_mode;
    logic [7:0]  r_high_hold,  n_high_hold;
    logic        r_addr_mm,    n_addr_mm;
    logic        r_code_mm,    n_code_mm;
    logic        r_out_valid,  n_out_valid;
    t_out_item   r_out,        n_out;

    logic        w_fire;
    logic [15:0] w_crc_next;
    logic        w_last;
    logic        w_in_data;
    logic [9:0]  w_off;
    logic        w_addr_mm;
    logic        w_code_mm;
    logic [2:0]  w_err;

    assign w_fire    = i_cmd_valid && (!r_out_valid || i_out_ready);
    assign o_cmd_pop = w_fire;

    assign w_crc_next = crc16_byte(r_crc, i_cmd.rx_byte);
    assign w_last     = ({1'b0, r_byte_count} + 11'd1) >= {1'b0, r_length};
    assign w_in_data  = (r_byte_count >= DATA_START)
                     && (({1'b0, r_byte_count} + 11'd2) < {1'b0, r_length});
    assign w_off      = r_byte_count - DATA_START;
    assign w_addr_mm  = r_addr_mm
                     || ((r_byte_count == 10'd0) && (i_cmd.rx_byte != r_exp_addr));
    assign w_code_mm  = r_code_mm
                     || ((r_byte_count == 10'd1) && (i_cmd.rx_byte != r_exp_code));

    always_comb begin
        if (w_crc_next != 16'd0) begin
            w_err = ERR_CRC;
        end else if (w_addr_mm) begin
            w_err = ERR_ADDR;
        end else if (w_code_mm) begin
            w_err = ERR_FUNCTION;
        end else begin
            w_err = ERR_OK;
        end
    end

    always_comb begin
        n_armed      = r_armed;
        n_crc        = r_crc;
        n_byte_count = r_byte_count;
        n_length     = r_length;
        n_exp_addr   = r_exp_addr;
        n_exp_code   = r_exp_code;
        n_mode       = r_mode;
        n_high_hold  = r_high_hold;
        n_addr_mm    = r_addr_mm;
        n_code_mm    = r_code_mm;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_out_ready;

        if (w_fire) begin
            n_out_valid = 1'b0;
            case (i_cmd.op)
                OP_ARM: begin
                    n_armed      = 1'b1;
                    n_crc        = CRC_INIT;
                    n_byte_count = '0;
                    n_length     = i_cmd.length;
                    n_exp_addr   = i_cmd.slave_addr;
                    n_exp_code   = i_cmd.function_code;
                    n_mode       = i_cmd.mode;
                    n_high_hold  = '0;
                    n_addr_mm    = 1'b0;
                    n_code_mm    = 1'b0;
                end
                OP_TIMEOUT: begin
                    if (r_armed) begin
                        n_armed     = 1'b0;
                        n_out_valid = 1'b1;
                        n_out       = '{kind: KIND_STATUS, data_value: 16'd0,
                                        data_index: 8'd0, error_code: ERR_SHORT};
                    end
                end
                OP_BYTE: begin
                    if (r_armed) begin
                        n_crc        = w_crc_next;
                        n_addr_mm    = w_addr_mm;
                        n_code_mm    = w_code_mm;
                        n_byte_count = r_byte_count + 10'd1;
                        if (w_last) begin
                            n_armed     = 1'b0;
                            n_out_valid = 1'b1;
                            n_out       = '{kind: KIND_STATUS, data_value: 16'd0,
                                            data_index: 8'd0, error_code: w_err};
                        end else if (w_in_data) begin
                            if (r_mode == MODE_BITS) begin
                                n_out_valid = 1'b1;
                                n_out       = '{kind: KIND_DATA,
                                                data_value: {8'd0, i_cmd.rx_byte},
                                                data_index: w_off[7:0],
                                                error_code: ERR_OK};
                            end else if (r_mode == MODE_REGS) begin
                                if (!w_off[0]) begin
                                    n_high_hold = i_cmd.rx_byte;
                                end else begin
                                    n_out_valid = 1'b1;
                                    n_out       = '{kind: KIND_DATA,
                                                    data_value: {r_high_hold,
                                                                 i_cmd.rx_byte},
                                                    data_index: w_off[8:1],
                                                    error_code: ERR_OK};
                                end
                            end
                        end
                    end
                end
                default: begin
                    n_out_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_armed     <= n_armed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc        <= n_crc;
        r_byte_count <= n_byte_count;
        r_length     <= n_length;
        r_exp_addr   <= n_exp_addr;
        r_exp_code   <= n_exp_code;
        r_mode       <= n_mode;
        r_high_hold  <= n_high_hold;
        r_addr_mm    <= n_addr_mm;
        r_code_mm    <= n_code_mm;
        r_out        <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

// File: rtl/modbus_rtu_response_checker.sv
// Top level of the Modbus RTU response checker: front end, command queue,
// back end. Depends on mrc_pkg, mrc_front, mrc_queue and mrc_back.
//
// Checks one Modbus RTU slave response per arm transaction. An arm transaction
// (func 0) loads the expected address, function code and quantity; the
// expected length is 5 + ceil(qty/8) for codes 1/2, 5 + 2*qty for codes 3/4,
// 8 otherwise, saturated at 1023. Byte transactions (func 1) run through a
// Modbus CRC-16 (0xA001 reflected, init 0xFFFF); read data comes out as
// data results (kind 0): big-endian words for register reads, raw packed
// bytes for bit reads. At the last expected byte one status result (kind 1)
// is produced, CRC error winning over address mismatch over function
// mismatch. A timeout (func 2) while armed gives status 1. Bytes and timeouts
// while idle, selector 3, and bytes past the frame end produce nothing.
// Data results are speculative: drop them if the status is not 0.
// Throughput is one transaction per clock while the queue is not full: the
// back end updates the CRC with a combinational, unrolled 8-bit step. From
// acceptance a result passes through the queue write, then the back-end output
// register. The queue of QUEUE_DEPTH commands lets input keep flowing while
// the result side is stalled; input ready drops only when the queue is full.
`default_nettype none

module modbus_rtu_response_checker #(
    parameter int QUEUE_DEPTH = mrc_pkg::QDEPTH_DEFAULT
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_ready,
    input  wire mrc_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire                     i_out_ready,
    output mrc_pkg::t_out_item      o_out_item
);
    import mrc_pkg::*;

    t_cmd w_front_cmd;
    logic w_front_keep;
    logic w_q_full;
    logic w_q_push;
    logic w_q_valid;
    t_cmd w_q_cmd;
    logic w_q_pop;

    // Front: classify the incoming transaction
    mrc_front u_front (
        .i_item (i_in_item),
        .o_cmd  (w_front_cmd),
        .o_keep (w_front_keep)
    );

    assign o_in_ready = !w_q_full;
    // Unused selector code is accepted and dropped here
    assign w_q_push   = i_in_valid && o_in_ready && w_front_keep;

    mrc_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    // Back: frame state and result register
    mrc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_cmd_pop   (w_q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

// File: test/modbus_rtu_response_checker_test.sv
// Self-checking testbench for modbus_rtu_response_checker: directed table, then random
// response frames with CRC, faults, timeouts and noise, checked against a local predictor.
// Depends on mrc_pkg and the modbus_rtu_response_checker RTL.
`timescale 1ns / 100ps

module modbus_rtu_response_checker_test;
    import mrc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // Modbus function codes used by the stimulus
    localparam logic [7:0] FC_READ_COILS      = 8'h01;
    localparam logic [7:0] FC_READ_INPUTS     = 8'h02;
    localparam logic [7:0] FC_READ_HOLDING    = 8'h03;
    localparam logic [7:0] FC_READ_INPUT_REGS = 8'h04;
    localparam logic [7:0] FC_WRITE_COIL      = 8'h05;
    localparam logic [7:0] FC_WRITE_REG       = 8'h06;
    localparam logic [7:0] FC_WRITE_COILS     = 8'h0F;
    localparam logic [7:0] FC_WRITE_REGS      = 8'h10;

    // How a directed byte row gets its value: as written, or from the frame CRC
    typedef enum logic [1:0] {
        FILL_NONE,
        FILL_CRC_LO,
        FILL_CRC_HI,
        FILL_CRC_BAD
    } t_fill;

    // Where the expected result of a directed row comes from
    typedef enum logic [1:0] {
        CHECK_PREDICT,
        CHECK_NONE,
        CHECK_STATUS
    } t_check;

    typedef struct {
        t_in_item   item;
        t_fill      fill;
        t_check     check;
        logic [2:0] err;
    } t_row;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_item = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_item;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_count = 0;
    int item_count = 0;
    int cycle_count = 0;

    t_out_item expected_results[$];

    // Predictor state
    logic       p_armed = 1'b0;
    logic [15:0] p_crc = CRC_INIT;
    logic [9:0] p_count = '0;
    int         p_len = 0;
    logic [7:0] p_addr = '0;
    logic [7:0] p_code = '0;
    t_read_mode p_mode = MODE_WRITE;
    logic [7:0] p_hold = '0;
    logic       p_addr_bad = 1'b0;
    logic       p_code_bad = 1'b0;

    modbus_rtu_response_checker dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    always #1 clk = ~clk;

    // Run limit: far beyond the slowest legal run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Modbus CRC-16, reflected, one byte LSB first
    function automatic logic [15:0] crc16_modbus_next(input logic [15:0] crc,
                                                      input logic [7:0] b);
        logic [15:0] r;
        r = crc ^ {8'h00, b};
        repeat (8) begin
            r = r[0] ? ({1'b0, r[15:1]} ^ CRC_POLY) : {1'b0, r[15:1]};
        end
        return r;
    endfunction

    // Frame length for an arm, saturated to the 10-bit counter range
    function automatic int frame_length(input logic [7:0] fc, input logic [8:0] qty);
        int n;
        if (fc == FC_READ_COILS || fc == FC_READ_INPUTS) begin
            n = 5 + ((int'(qty) + 7) >> 3);
        end else if (fc == FC_READ_HOLDING || fc == FC_READ_INPUT_REGS) begin
            n = 5 + 2 * int'(qty);
        end else begin
            n = int'(LEN_WRITE);
        end
        if (n > int'(LEN_MAX)) begin
            n = int'(LEN_MAX);
        end
        return n;
    endfunction

    // Predicts the result of one accepted transaction; returns the result count
    function automatic int predict_response(input t_in_item it, output t_out_item res);
        int pos;
        int off;
        res = '0;
        case (it.func)
            FUNC_ARM: begin
                if (it.function_code == FC_READ_COILS || it.function_code == FC_READ_INPUTS) begin
                    p_mode = MODE_BITS;
                end else if (it.function_code == FC_READ_HOLDING ||
                             it.function_code == FC_READ_INPUT_REGS) begin
                    p_mode = MODE_REGS;
                end else begin
                    p_mode = MODE_WRITE;
                end
                p_len      = frame_length(it.function_code, it.quantity);
                p_addr     = it.slave_addr;
                p_code     = it.function_code;
                p_armed    = 1'b1;
                p_crc      = CRC_INIT;
                p_count    = '0;
                p_hold     = '0;
                p_addr_bad = 1'b0;
                p_code_bad = 1'b0;
                return 0;
            end
            FUNC_TIMEOUT: begin
                if (!p_armed) begin
                    return 0;
                end
                p_armed        = 1'b0;
                res.kind       = KIND_STATUS;
                res.error_code = ERR_SHORT;
                return 1;
            end
            FUNC_BYTE: begin
                if (!p_armed) begin
                    return 0;
                end
                pos   = int'(p_count);
                p_crc = crc16_modbus_next(p_crc, it.rx_byte);
                if (pos == 0 && it.rx_byte != p_addr) begin
                    p_addr_bad = 1'b1;
                end
                if (pos == 1 && it.rx_byte != p_code) begin
                    p_code_bad = 1'b1;
                end
                p_count = 10'(pos + 1);
                // Last expected byte: status, CRC before address before code
                if (pos + 1 >= p_len) begin
                    p_armed  = 1'b0;
                    res.kind = KIND_STATUS;
                    if (p_crc != 16'h0000) begin
                        res.error_code = ERR_CRC;
                    end else if (p_addr_bad) begin
                        res.error_code = ERR_ADDR;
                    end else if (p_code_bad) begin
                        res.error_code = ERR_FUNCTION;
                    end else begin
                        res.error_code = ERR_OK;
                    end
                    return 1;
                end
                // Data part: from byte 3 up to the byte before the CRC
                if (pos >= 3 && pos + 2 < p_len) begin
                    off = pos - 3;
                    if (p_mode == MODE_BITS) begin
                        res.kind       = KIND_DATA;
                        res.data_value = {8'h00, it.rx_byte};
                        res.data_index = off[7:0];
                        return 1;
                    end
                    if (p_mode == MODE_REGS) begin
                        if (off[0] == 1'b0) begin
                            p_hold = it.rx_byte;
                        end else begin
                            off            = off >> 1;
                            res.kind       = KIND_DATA;
                            res.data_value = {p_hold, it.rx_byte};
                            res.data_index = off[7:0];
                            return 1;
                        end
                    end
                end
                return 0;
            end
            default: return 0;
        endcase
    endfunction

    // Every field random, so unused fields toggle too
    function automatic t_in_item random_item();
        t_in_item it;
        it.func          = 2'($urandom_range(0, 3));
        it.rx_byte       = 8'($urandom_range(0, 255));
        it.slave_addr    = 8'($urandom_range(0, 255));
        it.function_code = 8'($urandom_range(0, 255));
        it.quantity      = 9'($urandom_range(0, 511));
        return it;
    endfunction

    function automatic t_row row(input logic [1:0] func, input logic [7:0] b,
                                 input logic [7:0] addr, input logic [7:0] fc,
                                 input logic [8:0] qty, input t_fill fill,
                                 input t_check check, input logic [2:0] err);
        t_row r;
        r.item  = '{func: func, rx_byte: b, slave_addr: addr, function_code: fc,
                    quantity: qty};
        r.fill  = fill;
        r.check = check;
        r.err   = err;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Drives one transaction, waits for acceptance, stores its expected result
    task automatic send_item(input t_in_item it, input bit counted, input bit typed,
                             input bit typed_has, input logic [2:0] typed_err);
        t_out_item res;
        int n;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        n = predict_response(it, res);
        if (typed) begin
            if (typed_has) begin
                res            = '0;
                res.kind       = KIND_STATUS;
                res.error_code = typed_err;
                expected_results.push_back(res);
            end
        end else if (n > 0) begin
            expected_results.push_back(res);
        end
        if (counted) begin
            item_count++;
        end
        @(negedge clk);
    endtask

    // One response: arm, then up to cut bytes; faults corrupt address, code or CRC
    task automatic send_response(input logic [7:0] addr, input logic [7:0] fc,
                                 input logic [8:0] qty, input int cut, input bit faults,
                                 input bit counted);
        t_in_item it;
        logic [15:0] crc;
        logic [15:0] frame_crc;
        logic [7:0] b;
        int len;
        len              = frame_length(fc, qty);
        it               = random_item();
        it.func          = FUNC_ARM;
        it.slave_addr    = addr;
        it.function_code = fc;
        it.quantity      = qty;
        send_item(it, counted, 1'b0, 1'b0, ERR_OK);
        crc       = CRC_INIT;
        frame_crc = CRC_INIT;
        for (int i = 0; i < len && i < cut; i++) begin
            b = 8'($urandom_range(0, 255));
            if (i == 0) begin
                b = addr;
                if (faults && $urandom_range(0, 99) < 8) b ^= 8'($urandom_range(1, 255));
            end else if (i == 1) begin
                b = fc;
                if (faults && $urandom_range(0, 99) < 8) b ^= 8'($urandom_range(1, 255));
            end else if (i == len - 2) begin
                frame_crc = crc;
                b = crc[7:0];
            end else if (i == len - 1) begin
                b = frame_crc[15:8];
                if (faults && $urandom_range(0, 99) < 8) b ^= 8'($urandom_range(1, 255));
            end
            crc        = crc16_modbus_next(crc, b);
            it         = random_item();
            it.func    = FUNC_BYTE;
            it.rx_byte = b;
            send_item(it, counted, 1'b0, 1'b0, ERR_OK);
        end
    endtask

    task automatic send_control(input logic [1:0] func, input bit counted);
        t_in_item it;
        it      = random_item();
        it.func = func;
        send_item(it, counted, 1'b0, 1'b0, ERR_OK);
    endtask

    // Mostly well-formed frames, some truncated or noisy, a few oversized arms
    task automatic run_random(input int target);
        logic [7:0] fc;
        logic [8:0] qty;
        int pick;
        int len;
        int cut;
        while (item_count < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                case ($urandom_range(0, 9))
                    0, 1:    fc = 8'($urandom_range(FC_READ_COILS, FC_READ_INPUTS));
                    2, 3, 4: fc = 8'($urandom_range(FC_READ_HOLDING, FC_READ_INPUT_REGS));
                    5:       fc = FC_WRITE_COIL;
                    6:       fc = FC_WRITE_REG;
                    7:       fc = ($urandom_range(0, 1) != 0) ? FC_WRITE_COILS : FC_WRITE_REGS;
                    default: fc = 8'($urandom_range(0, 255));
                endcase
                if ($urandom_range(0, 99) < 4) begin
                    qty = 9'($urandom_range(13, 256));
                end else begin
                    qty = 9'($urandom_range(0, 12));
                end
                len = frame_length(fc, qty);
                cut = ($urandom_range(0, 99) < 10) ? $urandom_range(0, len - 1) : len;
                send_response(8'($urandom_range(0, 255)), fc, qty, cut, 1'b1, 1'b1);
                if (cut < len) begin
                    // Half the cut frames time out; the rest get re-armed over
                    if ($urandom_range(0, 1) != 0) send_control(FUNC_TIMEOUT, 1'b1);
                end else if ($urandom_range(0, 99) < 10) begin
                    repeat ($urandom_range(1, 3)) send_control(FUNC_BYTE, 1'b0);
                end
            end else if (pick < 85) begin
                case ($urandom_range(0, 2))
                    0:       send_control(FUNC_BYTE, 1'b0);
                    1:       send_control(FUNC_TIMEOUT, 1'b0);
                    default: send_control(FUNC_UNUSED, 1'b0);
                endcase
            end else begin
                // Quantity beyond the protocol range, length may saturate
                fc = 8'($urandom_range(FC_READ_COILS, FC_READ_INPUT_REGS));
                send_response(8'($urandom_range(0, 255)), fc, 9'($urandom_range(257, 511)),
                              $urandom_range(0, 12), 1'b1, 1'b1);
                send_control(FUNC_TIMEOUT, 1'b1);
            end
        end
    endtask

    // Result side: random stalls, set up on the falling edge
    always @(negedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk) begin : compare_results
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d value %h index %0d err %0d",
                                          out_item.kind, out_item.data_value,
                                          out_item.data_index, out_item.error_code));
            end else begin
                want = expected_results.pop_front();
                if (out_item.kind != want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", out_item.kind, want.kind));
                if (out_item.data_value != want.data_value)
                    report_mismatch($sformatf("data_value %h, want %h",
                                              out_item.data_value, want.data_value));
                if (out_item.data_index != want.data_index)
                    report_mismatch($sformatf("data_index %0d, want %0d",
                                              out_item.data_index, want.data_index));
                if (out_item.error_code != want.error_code)
                    report_mismatch($sformatf("error_code %0d, want %0d",
                                              out_item.error_code, want.error_code));
            end
        end
    end

    initial begin : stimulus
        t_row rows[$];
        t_in_item it;
        logic [15:0] frame_crc;
        logic [15:0] held_crc;
        frame_crc = CRC_INIT;
        held_crc  = CRC_INIT;

        // Idle block: stray byte, stray timeout, unused selector
        rows.push_back(row(FUNC_BYTE,    8'hFF, 8'h00, 8'h00, 9'd0, FILL_NONE, CHECK_NONE, ERR_OK));
        rows.push_back(row(FUNC_TIMEOUT, 8'h00, 8'hFF, 8'hFF, 9'd0, FILL_NONE, CHECK_NONE, ERR_OK));
        rows.push_back(row(FUNC_UNUSED,  8'hFF, 8'hFF, 8'hFF, 9'd256, FILL_NONE, CHECK_NONE,
                           ERR_OK));
        // Register read of one word, abandoned by a new arm before its CRC
        rows.push_back(row(FUNC_ARM,  8'h00, 8'hFF, FC_READ_HOLDING, 9'd1, FILL_NONE,
                           CHECK_NONE, ERR_OK));
        rows.push_back(row(FUNC_BYTE, 8'hFF, 8'h00, 8'h00, 9'd0, FILL_NONE, CHECK_PREDICT, ERR_OK));
        rows.push_back(row(FUNC_BYTE, 8'h03, 8'h00, 8'h00, 9'd0, FILL_NONE, CHECK_PREDICT, ERR_OK));
        rows.push_back(row(FUNC_BYTE, 8'h02, 8'h00, 8'h00, 9'd0, FILL_NONE, CHECK_PREDICT, ERR_OK));
        rows.push_back(row(FUNC_BYTE, 8'hFF, 8'h00, 8'h00, 9'd0, FILL_NONE, CHECK_PREDICT, ERR_OK));
        rows.push_back(row(FUNC_BYTE, 8'h00, 8'h00, 8'h00, 9'd0, FILL_NONE, CHECK_PREDICT, ERR_OK));
        // Bit read at quantity 256, then a timeout mid-frame
        rows.push_back(row(FUNC_ARM,  8'hFF, 8'h00, FC_READ_COILS, 9'd256, FILL_NONE,
                           CHECK_NONE, ERR_OK));
        rows.push_back(row(FUNC_BYTE, 8'h01, 8'h00, 8'h00, 9'd0, FILL_NONE, CHECK_NONE, ERR_OK));
        rows.push_back(row(FUNC_BYTE, 8'h02, 8'h00, 8'h00, 9'd0, FILL_NONE, CHECK_NONE, ERR_OK));
        rows.push_back(row(FUNC_TIMEOUT, 8'h00, 8'h00, 8'h00, 9'd0, FILL_NONE, CHECK_STATUS,
                           ERR_SHORT));
        // Good CRC, wrong address and code: address wins
        rows.push_back(row(FUNC_ARM,  8'h00, 8'h12, FC_READ_INPUTS, 9'd0, FILL_NONE,
                           CHECK_NONE, ERR_OK));
        rows.push_back(row(FUNC_BYTE, 8'h13, 8'h00, 8'h00, 9'd0, FILL_NONE, CHECK_NONE, ERR_OK));
        rows.push_back(row(FUNC_BYTE, 8'h03, 8'h00, 8'h00, 9'd0, FILL_NONE, CHECK_NONE, ERR_OK));
        rows.push_back(row(FUNC_BYTE, 8'h00, 8'h00, 8'h00, 9'd0, FILL_NONE, CHECK_NONE, ERR_OK));
        rows.push_back(row(FUNC_BYTE, 8'h00, 8'h00, 8'h00, 9'd0, FILL_CRC_LO, CHECK_NONE, ERR_OK));
        rows.push_back(row(FUNC_BYTE, 8'h00, 8'h00, 8'h00, 9'd0, FILL_CRC_HI, CHECK_STATUS,
                           ERR_ADDR));
        // Broken CRC with a code mismatch: CRC wins
        rows.push_back(row(FUNC_ARM,  8'h00, 8'h12, FC_READ_INPUT_REGS, 9'd0, FILL_NONE,
                           CHECK_NONE, ERR_OK));
        rows.push_back(row(FUNC_BYTE, 8'h12, 8'h00, 8'h00, 9'd0, FILL_NONE, CHECK_NONE, ERR_OK));
        rows.push_back(row(FUNC_BYTE, 8'h03, 8'h00, 8'h00, 9'd0, FILL_NONE, CHECK_NONE, ERR_OK));
        rows.push_back(row(FUNC_BYTE, 8'h00, 8'h00, 8'h00, 9'd0, FILL_NONE, CHECK_NONE, ERR_OK));
        rows.push_back(row(FUNC_BYTE, 8'h00, 8'h00, 8'h00, 9'd0, FILL_CRC_LO, CHECK_NONE, ERR_OK));
        rows.push_back(row(FUNC_BYTE, 8'h00, 8'h00, 8'h00, 9'd0, FILL_CRC_BAD, CHECK_STATUS,
                           ERR_CRC));

        send_idle_pct = 7;
        recv_idle_pct = 45;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i]) begin
            it = rows[i].item;
            if (it.func == FUNC_ARM) begin
                frame_crc = CRC_INIT;
            end else if (it.func == FUNC_BYTE) begin
                case (rows[i].fill)
                    FILL_CRC_LO: begin
                        held_crc   = frame_crc;
                        it.rx_byte = frame_crc[7:0];
                    end
                    FILL_CRC_HI:  it.rx_byte = held_crc[15:8];
                    FILL_CRC_BAD: it.rx_byte = held_crc[15:8] ^ 8'h01;
                    default: ;
                endcase
                frame_crc = crc16_modbus_next(frame_crc, it.rx_byte);
            end
            send_item(it, 1'b0, rows[i].check != CHECK_PREDICT, rows[i].check == CHECK_STATUS,
                      rows[i].err);
        end

        item_count = 0;
        run_random(240);

        send_idle_pct = 45;
        recv_idle_pct = 7;
        // Register read at the saturated length, cut once indexes wrap past 255
        send_response(8'($urandom_range(0, 255)), FC_READ_HOLDING, 9'd511, 530,
                      1'b0, 1'b1);
        send_control(FUNC_TIMEOUT, 1'b1);
        run_random(830);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(900);
        in_valid <= 1'b0;

        while (expected_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
